[src/iee_pkg.sv]
// Package for the infix expression evaluator.
// Token, operator and status codes, sequencer state types and the
// precedence function. No dependencies.
`default_nettype none
package iee_pkg;

  localparam int VALUE_DEPTH_DEF    = 32;
  localparam int OPERATOR_DEPTH_DEF = 32;

  // token kinds
  localparam logic [2:0] KIND_NUM   = 3'd0;
  localparam logic [2:0] KIND_OPER  = 3'd1;
  localparam logic [2:0] KIND_OPEN  = 3'd2;
  localparam logic [2:0] KIND_CLOSE = 3'd3;
  localparam logic [2:0] KIND_END   = 3'd4;

  // operator codes, plus the bracket marker kept on the operator stack
  localparam logic [2:0] OP_ADD  = 3'd0;
  localparam logic [2:0] OP_SUB  = 3'd1;
  localparam logic [2:0] OP_MUL  = 3'd2;
  localparam logic [2:0] OP_DIV  = 3'd3;
  localparam logic [2:0] OP_REM  = 3'd4;
  localparam logic [2:0] OP_POW  = 3'd5;
  localparam logic [2:0] OP_MARK = 3'd6;

  // result status
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_DIVZERO   = 2'd1;
  localparam logic [1:0] ST_OVERFLOW  = 2'd2;
  localparam logic [1:0] ST_MALFORMED = 2'd3;

  // precedence levels
  localparam logic [3:0] RANK_ADD  = 4'd5;
  localparam logic [3:0] RANK_MUL  = 4'd10;
  localparam logic [3:0] RANK_REM  = 4'd12;
  localparam logic [3:0] RANK_POW  = 4'd15;
  localparam logic [3:0] RANK_NONE = 4'd0;
  localparam logic [3:0] RANK_ALL  = 4'd1;

  typedef enum logic [2:0] {
    S_IDLE, S_DISPATCH, S_REDUCE, S_ALU, S_REFILL, S_FINISH
  } seq_state_t;

  typedef enum logic [1:0] {
    M_OPER, M_CLOSE, M_END
  } red_mode_t;

  typedef enum logic [2:0] {
    AL_IDLE, AL_MUL, AL_DIV, AL_POW_A, AL_POW_B, AL_DONE
  } alu_state_t;

  typedef struct packed {
    logic        start;
    logic [2:0]  op;
    logic [31:0] a;
    logic [31:0] b;
  } alu_req_t;

  typedef struct packed {
    logic        done;
    logic        divzero;
    logic [31:0] result;
  } alu_rsp_t;

  function automatic logic [3:0] rank(input logic [2:0] op);
    logic [3:0] r;
    case (op)
      OP_ADD, OP_SUB: r = RANK_ADD;
      OP_MUL, OP_DIV: r = RANK_MUL;
      OP_REM:         r = RANK_REM;
      OP_POW:         r = RANK_POW;
      default:        r = RANK_NONE;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

[src/iee_ifs.sv]
// Valid/ready channel interfaces for token input and result output.
// Standalone; no package use.
`default_nettype none
interface iee_tok_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [30:0] number_value;
  logic [2:0]  operator_code;
  modport source (output valid, kind, number_value, operator_code, input ready);
  modport sink   (input valid, kind, number_value, operator_code, output ready);
endinterface

interface iee_res_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] result_value;
  logic [1:0]         status;
  modport source (output valid, result_value, status, input ready);
  modport sink   (input valid, result_value, status, output ready);
endinterface
`default_nettype wire

[src/iee_alu.sv]
// Shared arithmetic unit: one 32x32 multiplier, a restoring divider
// (one quotient bit per cycle) and square-and-multiply power.
// Depends on iee_pkg.
`default_nettype none
module iee_alu (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire iee_pkg::alu_req_t req,
  output iee_pkg::alu_rsp_t rsp
);

  iee_pkg::alu_state_t state, state_next;
  logic [2:0]  op;
  logic [31:0] opa, opb;
  logic [31:0] result;
  logic        divzero;
  logic [32:0] rem;
  logic [31:0] quo, dmag;
  logic        qneg, rneg;
  logic [4:0]  cnt;
  logic [31:0] acc, base, ex;
  logic [31:0] mul_x, mul_y;
  logic [63:0] mul_full;
  logic [32:0] trial, rem_n;
  logic [31:0] quo_n;
  logic [31:0] amag_in, bmag_in;

  // multiplier operand select
  always_comb begin
    mul_x = opa;
    mul_y = opb;
    if (state == iee_pkg::AL_POW_A) begin
      mul_x = acc;
      mul_y = base;
    end else if (state == iee_pkg::AL_POW_B) begin
      mul_x = base;
      mul_y = base;
    end
  end
  assign mul_full = mul_x * mul_y;

  // one restoring divide step
  always_comb begin
    trial = {rem[31:0], quo[31]} - {1'b0, dmag};
    if (!trial[32]) begin
      rem_n = trial;
      quo_n = {quo[30:0], 1'b1};
    end else begin
      rem_n = {rem[31:0], quo[31]};
      quo_n = {quo[30:0], 1'b0};
    end
  end

  assign amag_in = req.a[31] ? (32'd0 - req.a) : req.a;
  assign bmag_in = req.b[31] ? (32'd0 - req.b) : req.b;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      iee_pkg::AL_IDLE: begin
        if (req.start) begin
          case (req.op)
            iee_pkg::OP_MUL: state_next = iee_pkg::AL_MUL;
            iee_pkg::OP_DIV, iee_pkg::OP_REM:
              state_next = (req.b == 32'd0) ? iee_pkg::AL_DONE : iee_pkg::AL_DIV;
            iee_pkg::OP_POW:
              state_next = req.b[31] ? iee_pkg::AL_DONE : iee_pkg::AL_POW_A;
            default: state_next = iee_pkg::AL_DONE;
          endcase
        end
      end
      iee_pkg::AL_MUL:   state_next = iee_pkg::AL_DONE;
      iee_pkg::AL_DIV:   if (cnt == 5'd31) state_next = iee_pkg::AL_DONE;
      iee_pkg::AL_POW_A: state_next = (ex == 32'd0) ? iee_pkg::AL_DONE : iee_pkg::AL_POW_B;
      iee_pkg::AL_POW_B: state_next = iee_pkg::AL_POW_A;
      iee_pkg::AL_DONE:  state_next = iee_pkg::AL_IDLE;
      default:           state_next = iee_pkg::AL_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    rsp.done    = (state == iee_pkg::AL_DONE);
    rsp.divzero = divzero;
    rsp.result  = result;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= iee_pkg::AL_IDLE;
      divzero <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        iee_pkg::AL_IDLE: begin
          if (req.start) begin
            op      <= req.op;
            opa     <= req.a;
            opb     <= req.b;
            divzero <= 1'b0;
            case (req.op)
              iee_pkg::OP_ADD: result <= req.a + req.b;
              iee_pkg::OP_SUB: result <= req.a - req.b;
              iee_pkg::OP_DIV, iee_pkg::OP_REM: begin
                divzero <= (req.b == 32'd0);
                rem     <= 33'd0;
                quo     <= amag_in;
                dmag    <= bmag_in;
                qneg    <= req.a[31] ^ req.b[31];
                rneg    <= req.a[31];
                cnt     <= 5'd0;
              end
              iee_pkg::OP_POW: begin
                // negative exponent: only bases 1 and -1 survive
                if (req.a == 32'd1)
                  result <= 32'd1;
                else if (req.a == 32'hFFFF_FFFF)
                  result <= req.b[0] ? 32'hFFFF_FFFF : 32'd1;
                else
                  result <= 32'd0;
                acc  <= 32'd1;
                base <= req.a;
                ex   <= req.b;
              end
              default: result <= 32'd0;
            endcase
          end
        end
        iee_pkg::AL_MUL: result <= mul_full[31:0];
        iee_pkg::AL_DIV: begin
          rem <= rem_n;
          quo <= quo_n;
          cnt <= cnt + 5'd1;
          if (cnt == 5'd31) begin
            if (op == iee_pkg::OP_DIV)
              result <= qneg ? (32'd0 - quo_n) : quo_n;
            else
              result <= rneg ? (32'd0 - rem_n[31:0]) : rem_n[31:0];
          end
        end
        iee_pkg::AL_POW_A: begin
          if (ex == 32'd0)
            result <= acc;
          else if (ex[0])
            acc <= mul_full[31:0];
        end
        iee_pkg::AL_POW_B: begin
          base <= mul_full[31:0];
          ex   <= {1'b0, ex[31:1]};
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

[src/infix_expression_evaluator_core.sv]
// Infix expression evaluator, top level: token sequencer, value and
// operator stacks. Depends on iee_pkg, iee_ifs and iee_alu.
//
// Takes one token word at a time and evaluates the expression with a value
// stack and an operator stack, giving one result word on end of expression.
// The top two values and the top operator sit in registers; deeper entries
// live in small memories with registered reads. Each operator applied by a
// reduction, add and subtract included, runs on the one shared arithmetic
// unit, which divides one quotient bit per cycle. End of expression waits
// while an earlier result word is not yet taken.
`default_nettype none
module infix_expression_evaluator_core #(
  parameter int VALUE_DEPTH    = iee_pkg::VALUE_DEPTH_DEF,
  parameter int OPERATOR_DEPTH = iee_pkg::OPERATOR_DEPTH_DEF
) (
  input wire logic clk,
  input wire logic rst,
  iee_tok_if.sink   tok,
  iee_res_if.source res
);

  localparam int VCW = $clog2(VALUE_DEPTH + 1);
  localparam int OCW = $clog2(OPERATOR_DEPTH + 1);
  localparam int VAW = $clog2(VALUE_DEPTH);
  localparam int OAW = $clog2(OPERATOR_DEPTH);

  iee_pkg::seq_state_t state, state_next;
  iee_pkg::red_mode_t  mode;
  iee_pkg::alu_req_t   alu_req;
  iee_pkg::alu_rsp_t   alu_rsp;

  logic [2:0]     tk_kind;
  logic [30:0]    tk_num;
  logic [2:0]     tk_op;
  logic [3:0]     level;
  logic [1:0]     err;
  logic [31:0]    top_val, sec_val;
  logic [VCW-1:0] vcount;
  logic [2:0]     op_top;
  logic [OCW-1:0] ocount;
  logic           refill_val;

  logic [31:0] vmem [VALUE_DEPTH];
  logic [2:0]  omem [OPERATOR_DEPTH];
  logic [31:0] vmem_q;
  logic [2:0]  omem_q;

  logic           red_more, v_full, o_full, err_ok;
  logic           v_we, o_push, o_we;
  logic [2:0]     push_code;
  logic [VCW-1:0] v_wa_w, v_ra_w;
  logic [OCW-1:0] o_wa_w, o_ra_w;
  logic           flag_en;
  logic [1:0]     flag_code;

  assign err_ok   = (err == iee_pkg::ST_OK);
  assign v_full   = (vcount >= VCW'(VALUE_DEPTH));
  assign o_full   = (ocount >= OCW'(OPERATOR_DEPTH));
  assign red_more = (ocount != '0) && (op_top != iee_pkg::OP_MARK) &&
                    (iee_pkg::rank(op_top) >= level);

  iee_alu u_alu (
    .clk (clk),
    .rst (rst),
    .req (alu_req),
    .rsp (alu_rsp)
  );

  always_comb begin
    alu_req.start = (state == iee_pkg::S_REDUCE) && red_more && (vcount >= VCW'(2));
    alu_req.op    = op_top;
    alu_req.a     = sec_val;
    alu_req.b     = top_val;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      iee_pkg::S_IDLE: if (tok.valid) state_next = iee_pkg::S_DISPATCH;
      iee_pkg::S_DISPATCH: begin
        if (tk_kind == iee_pkg::KIND_END)
          state_next = err_ok ? iee_pkg::S_REDUCE : iee_pkg::S_FINISH;
        else if (err_ok && (tk_kind == iee_pkg::KIND_CLOSE ||
                 (tk_kind == iee_pkg::KIND_OPER && tk_op <= iee_pkg::OP_POW)))
          state_next = iee_pkg::S_REDUCE;
        else
          state_next = iee_pkg::S_IDLE;
      end
      iee_pkg::S_REDUCE: begin
        if (red_more) begin
          if (vcount >= VCW'(2))
            state_next = iee_pkg::S_ALU;
          else
            state_next = (mode == iee_pkg::M_END) ? iee_pkg::S_FINISH : iee_pkg::S_IDLE;
        end else begin
          case (mode)
            iee_pkg::M_END:   state_next = iee_pkg::S_FINISH;
            iee_pkg::M_CLOSE: state_next = (ocount != '0) ? iee_pkg::S_REFILL : iee_pkg::S_IDLE;
            default:          state_next = iee_pkg::S_IDLE;
          endcase
        end
      end
      iee_pkg::S_ALU: begin
        if (alu_rsp.done) begin
          if (alu_rsp.divzero)
            state_next = (mode == iee_pkg::M_END) ? iee_pkg::S_FINISH : iee_pkg::S_IDLE;
          else
            state_next = iee_pkg::S_REFILL;
        end
      end
      iee_pkg::S_REFILL: state_next = refill_val ? iee_pkg::S_REDUCE : iee_pkg::S_IDLE;
      iee_pkg::S_FINISH: if (!res.valid || res.ready) state_next = iee_pkg::S_IDLE;
      default: state_next = iee_pkg::S_IDLE;
    endcase
  end

  // handshake and error outputs
  always_comb begin
    tok.ready = (state == iee_pkg::S_IDLE);
    flag_en   = 1'b0;
    flag_code = iee_pkg::ST_MALFORMED;
    case (state)
      iee_pkg::S_DISPATCH: begin
        case (tk_kind)
          iee_pkg::KIND_NUM: begin
            flag_en   = v_full;
            flag_code = iee_pkg::ST_OVERFLOW;
          end
          iee_pkg::KIND_OPER: flag_en = (tk_op > iee_pkg::OP_POW);
          iee_pkg::KIND_OPEN: begin
            flag_en   = o_full;
            flag_code = iee_pkg::ST_OVERFLOW;
          end
          iee_pkg::KIND_CLOSE, iee_pkg::KIND_END: flag_en = 1'b0;
          default: flag_en = 1'b1;
        endcase
      end
      iee_pkg::S_REDUCE: begin
        if (red_more)
          flag_en = (vcount < VCW'(2));
        else begin
          case (mode)
            iee_pkg::M_OPER: begin
              flag_en   = o_full;
              flag_code = iee_pkg::ST_OVERFLOW;
            end
            iee_pkg::M_CLOSE: flag_en = (ocount == '0);
            default:          flag_en = (ocount != '0) || (vcount != VCW'(1));
          endcase
        end
      end
      iee_pkg::S_ALU: begin
        flag_en   = alu_rsp.done && alu_rsp.divzero;
        flag_code = iee_pkg::ST_DIVZERO;
      end
      default: ;
    endcase
  end

  // stack write controls
  always_comb begin
    v_we = (state == iee_pkg::S_DISPATCH) && err_ok && (tk_kind == iee_pkg::KIND_NUM) &&
           !v_full;
    o_push = ((state == iee_pkg::S_DISPATCH) && err_ok && (tk_kind == iee_pkg::KIND_OPEN)) ||
             ((state == iee_pkg::S_REDUCE) && !red_more && (mode == iee_pkg::M_OPER));
    o_push    = o_push && !o_full;
    push_code = (state == iee_pkg::S_DISPATCH) ? iee_pkg::OP_MARK : tk_op;
    o_we      = o_push && (ocount != '0);
    v_wa_w    = vcount - VCW'(2);
    o_wa_w    = ocount - OCW'(1);
    v_ra_w    = vcount - VCW'(3);
    o_ra_w    = ocount - OCW'(2);
  end

  // stack memories below the cached top entries
  always_ff @(posedge clk) begin
    if (v_we && (vcount >= VCW'(2)))
      vmem[v_wa_w[VAW-1:0]] <= sec_val;
    vmem_q <= vmem[v_ra_w[VAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (o_we)
      omem[o_wa_w[OAW-1:0]] <= op_top;
    omem_q <= omem[o_ra_w[OAW-1:0]];
  end

  // sequencer datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= iee_pkg::S_IDLE;
      vcount    <= '0;
      ocount    <= '0;
      err       <= iee_pkg::ST_OK;
      res.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (res.valid && res.ready && state != iee_pkg::S_FINISH)
        res.valid <= 1'b0;
      if (flag_en && err_ok)
        err <= flag_code;
      if (v_we) begin
        sec_val <= top_val;
        top_val <= {1'b0, tk_num};
        vcount  <= vcount + VCW'(1);
      end
      if (o_push) begin
        op_top <= push_code;
        ocount <= ocount + OCW'(1);
      end
      case (state)
        iee_pkg::S_IDLE: begin
          tk_kind <= tok.kind;
          tk_num  <= tok.number_value;
          tk_op   <= tok.operator_code;
        end
        iee_pkg::S_DISPATCH: begin
          case (tk_kind)
            iee_pkg::KIND_OPER: begin
              mode  <= iee_pkg::M_OPER;
              level <= iee_pkg::rank(tk_op);
            end
            iee_pkg::KIND_CLOSE: begin
              mode  <= iee_pkg::M_CLOSE;
              level <= iee_pkg::RANK_ALL;
            end
            default: begin
              mode  <= iee_pkg::M_END;
              level <= iee_pkg::RANK_ALL;
            end
          endcase
        end
        iee_pkg::S_REDUCE: begin
          // close bracket: drop the marker
          if (!red_more && mode == iee_pkg::M_CLOSE && ocount != '0) begin
            ocount     <= ocount - OCW'(1);
            refill_val <= 1'b0;
          end
        end
        iee_pkg::S_ALU: begin
          if (alu_rsp.done && !alu_rsp.divzero) begin
            top_val    <= alu_rsp.result;
            vcount     <= vcount - VCW'(1);
            ocount     <= ocount - OCW'(1);
            refill_val <= 1'b1;
          end
        end
        iee_pkg::S_REFILL: begin
          if (refill_val && vcount >= VCW'(2))
            sec_val <= vmem_q;
          if (ocount != '0)
            op_top <= omem_q;
        end
        iee_pkg::S_FINISH: begin
          if (!res.valid || res.ready) begin
            res.valid        <= 1'b1;
            res.result_value <= err_ok ? top_val : 32'sd0;
            res.status       <= err;
            vcount           <= '0;
            ocount           <= '0;
            err              <= iee_pkg::ST_OK;
          end
        end
        default: ;
      endcase
    end
  end

  a_vcount_range: assert property (@(posedge clk) disable iff (rst)
    vcount <= VCW'(VALUE_DEPTH))
    else $error("value count above depth");

  a_ocount_range: assert property (@(posedge clk) disable iff (rst)
    ocount <= OCW'(OPERATOR_DEPTH))
    else $error("operator count above depth");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    res.valid && (res.status != iee_pkg::ST_OK) |-> (res.result_value == 32'sd0))
    else $error("error word carries nonzero value");

  a_alu_only_in_reduce: assert property (@(posedge clk) disable iff (rst)
    alu_rsp.done |-> (state == iee_pkg::S_ALU))
    else $error("arithmetic unit finished outside wait state");

endmodule
`default_nettype wire

[tb/sv/tb_infix_expression_evaluator_core.sv]
// Testbench for the infix expression evaluator core.
// Predicts each result word from the token stream and checks it.
// Depends on iee_pkg, iee_ifs and the core.
`timescale 1ns / 1ps
module tb_infix_expression_evaluator_core;

  localparam int VDEPTH = iee_pkg::VALUE_DEPTH_DEF;
  localparam int ODEPTH = iee_pkg::OPERATOR_DEPTH_DEF;

  logic clk = 1'b0;
  logic rst = 1'b1;

  iee_tok_if tok ();
  iee_res_if res ();

  infix_expression_evaluator_core uut (
    .clk(clk),
    .rst(rst),
    .tok(tok.sink),
    .res(res.source)
  );

  always #5 clk = ~clk;

  typedef struct packed {
    logic [31:0] value;
    logic [1:0]  status;
  } answer_t;

  // predictor state
  logic [31:0] vals [VDEPTH];
  logic [2:0]  ops [ODEPTH];
  int          vcnt;
  int          ocnt;
  logic [1:0]  err;

  answer_t answers [$];
  int      errors;
  int      n_tokens;
  int      n_results;
  int      n_bad_status;
  int      hold_cycles;
  bit      sink_long_hold;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void note_err(logic [1:0] code);
    if (err == iee_pkg::ST_OK) err = code;
  endfunction

  function automatic logic [3:0] prec(logic [2:0] op);
    case (op)
      iee_pkg::OP_ADD, iee_pkg::OP_SUB: return 4'd5;
      iee_pkg::OP_MUL, iee_pkg::OP_DIV: return 4'd10;
      iee_pkg::OP_REM:                  return 4'd12;
      iee_pkg::OP_POW:                  return 4'd15;
      default:                          return 4'd0;
    endcase
  endfunction

  function automatic logic [31:0] int_pow(logic [31:0] base, logic [31:0] ex);
    logic [31:0] acc;
    acc = 32'd1;
    if (ex[31]) begin
      if (base == 32'd1) return 32'd1;
      if (base == 32'hFFFF_FFFF) return ex[0] ? 32'hFFFF_FFFF : 32'd1;
      return 32'd0;
    end
    while (ex != 0) begin
      if (ex[0]) acc = acc * base;
      base = base * base;
      ex = ex >> 1;
    end
    return acc;
  endfunction

  // apply top operator to top two values
  function automatic bit fold_top();
    logic [31:0] a, b, r;
    logic [2:0]  op;
    if (ocnt == 0 || vcnt < 2) begin
      note_err(iee_pkg::ST_MALFORMED);
      return 1'b0;
    end
    op = ops[ocnt-1];
    b = vals[vcnt-1];
    a = vals[vcnt-2];
    case (op)
      iee_pkg::OP_ADD: r = a + b;
      iee_pkg::OP_SUB: r = a - b;
      iee_pkg::OP_MUL: r = a * b;
      iee_pkg::OP_DIV, iee_pkg::OP_REM: begin
        if (b == 0) begin
          note_err(iee_pkg::ST_DIVZERO);
          return 1'b0;
        end
        if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF)
          r = (op == iee_pkg::OP_DIV) ? 32'h8000_0000 : 32'd0;
        else if (op == iee_pkg::OP_DIV)
          r = $signed(a) / $signed(b);
        else
          r = $signed(a) % $signed(b);
      end
      iee_pkg::OP_POW: r = int_pow(a, b);
      default: begin
        note_err(iee_pkg::ST_MALFORMED);
        return 1'b0;
      end
    endcase
    ocnt--;
    vcnt--;
    vals[vcnt-1] = r;
    return 1'b1;
  endfunction

  function automatic bit fold_down(logic [3:0] level);
    logic [2:0] top;
    while (ocnt > 0) begin
      top = ops[ocnt-1];
      if (top == iee_pkg::OP_MARK || prec(top) < level) break;
      if (!fold_top()) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void push_op(logic [2:0] code);
    if (ocnt >= ODEPTH) note_err(iee_pkg::ST_OVERFLOW);
    else begin
      ops[ocnt] = code;
      ocnt++;
    end
  endfunction

  // evaluate one accepted token word
  function automatic void eval_token(logic [2:0] kind, logic [30:0] num,
                                     logic [2:0] opc);
    answer_t ans;
    if (kind == iee_pkg::KIND_END) begin
      ans.value = '0;
      if (err == iee_pkg::ST_OK && fold_down(4'd1)) begin
        if (ocnt != 0 || vcnt != 1) note_err(iee_pkg::ST_MALFORMED);
        else ans.value = vals[0];
      end
      if (err != iee_pkg::ST_OK) ans.value = '0;
      ans.status = err;
      answers.push_back(ans);
      vcnt = 0;
      ocnt = 0;
      err = iee_pkg::ST_OK;
      return;
    end
    if (err != iee_pkg::ST_OK) return;
    case (kind)
      iee_pkg::KIND_NUM: begin
        if (vcnt >= VDEPTH) note_err(iee_pkg::ST_OVERFLOW);
        else begin
          vals[vcnt] = {1'b0, num};
          vcnt++;
        end
      end
      iee_pkg::KIND_OPER: begin
        if (opc > iee_pkg::OP_POW) note_err(iee_pkg::ST_MALFORMED);
        else if (fold_down(prec(opc))) push_op(opc);
      end
      iee_pkg::KIND_OPEN: push_op(iee_pkg::OP_MARK);
      iee_pkg::KIND_CLOSE: begin
        if (fold_down(4'd1)) begin
          if (ocnt == 0) note_err(iee_pkg::ST_MALFORMED);
          else ocnt--;
        end
      end
      default: note_err(iee_pkg::ST_MALFORMED);
    endcase
  endfunction

  // send one token word, with an optional random gap first
  task automatic send_token(logic [2:0] kind, logic [30:0] num, logic [2:0] opc,
                            bit gaps = 1'b1);
    int g;
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      tok.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    tok.valid <= 1'b1;
    tok.kind <= kind;
    tok.number_value <= num;
    tok.operator_code <= opc;
    do @(posedge clk); while (!tok.ready);
    eval_token(kind, num, opc);
    n_tokens++;
  endtask

  task automatic wait_drain();
    tok.valid <= 1'b0;
    while (answers.size() != 0) @(posedge clk);
  endtask

  // sink side: random stalls, plus one long hold on request
  always @(posedge clk) begin
    if (rst) res.ready <= 1'b0;
    else if (sink_long_hold) begin
      res.ready <= 1'b0;
      hold_cycles <= hold_cycles + 1;
      if (hold_cycles >= 400) sink_long_hold <= 1'b0;
    end else res.ready <= ($urandom_range(0, 99) < 70);
  end

  // result checker
  always @(posedge clk) begin
    answer_t e;
    if (!rst && res.valid && res.ready) begin
      n_results++;
      if (answers.size() == 0) begin
        $display("%0t: unexpected result word value=%0d status=%0d",
                 $time, res.result_value, res.status);
        errors++;
      end else begin
        e = answers.pop_front();
        if (res.status != iee_pkg::ST_OK) n_bad_status++;
        if (res.result_value !== e.value) begin
          $display("%0t: result_value expected %0d got %0d", $time,
                   $signed(e.value), res.result_value);
          errors++;
        end
        if (res.status !== e.status) begin
          $display("%0t: status expected %0d got %0d", $time, e.status,
                   res.status);
          errors++;
        end
      end
    end
  end

  function automatic logic [30:0] rand_num();
    case ($urandom_range(0, 5))
      0: return 31'd0;
      1: return 31'd1;
      2: return 31'($urandom_range(0, 9));
      3: return 31'h7FFF_FFFF;
      default: return 31'($urandom());
    endcase
  endfunction

  function automatic logic [2:0] rand_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 2) return 3'($urandom_range(6, 7));
    if (r < 12) return iee_pkg::OP_POW;
    return 3'($urandom_range(0, 4));
  endfunction

  // directed cases: extremes, every operator but add and the listed corner cases
  task automatic test_directed();
    // 7 ^ 3
    send_token(iee_pkg::KIND_NUM, 7, iee_pkg::OP_ADD);
    send_token(iee_pkg::KIND_OPER, 0, iee_pkg::OP_POW);
    send_token(iee_pkg::KIND_NUM, 3, iee_pkg::OP_ADD);
    send_token(iee_pkg::KIND_END, 0, iee_pkg::OP_ADD);
    // (max - max*2) / 0 -> divide by zero
    send_token(iee_pkg::KIND_OPEN, 0, iee_pkg::OP_ADD);
    send_token(iee_pkg::KIND_NUM, 31'h7FFFFFFF, iee_pkg::OP_ADD);
    send_token(iee_pkg::KIND_OPER, 0, iee_pkg::OP_SUB);
    send_token(iee_pkg::KIND_NUM, 31'h7FFFFFFF, iee_pkg::OP_ADD);
    send_token(iee_pkg::KIND_OPER, 0, iee_pkg::OP_MUL);
    send_token(iee_pkg::KIND_NUM, 2, iee_pkg::OP_ADD);
    send_token(iee_pkg::KIND_CLOSE, 0, iee_pkg::OP_ADD);
    send_token(iee_pkg::KIND_OPER, 0, iee_pkg::OP_DIV);
    send_token(iee_pkg::KIND_NUM, 0, iee_pkg::OP_ADD);
    send_token(iee_pkg::KIND_END, 0, iee_pkg::OP_ADD);
    // 9 % 4 , unmatched close, bad kind, bad opcode, empty expression
    send_token(iee_pkg::KIND_NUM, 9, iee_pkg::OP_ADD);
    send_token(iee_pkg::KIND_OPER, 0, iee_pkg::OP_REM);
    send_token(iee_pkg::KIND_NUM, 4, iee_pkg::OP_ADD);
    send_token(iee_pkg::KIND_CLOSE, 0, iee_pkg::OP_ADD);
    send_token(iee_pkg::KIND_END, 0, iee_pkg::OP_ADD);
    send_token(3'd7, 31'h7FFFFFFF, 3'd7);
    send_token(iee_pkg::KIND_END, 0, iee_pkg::OP_ADD);
    send_token(iee_pkg::KIND_NUM, 1, iee_pkg::OP_ADD);
    send_token(iee_pkg::KIND_OPER, 0, 3'd6);
    send_token(iee_pkg::KIND_END, 0, iee_pkg::OP_ADD);
    send_token(iee_pkg::KIND_END, 0, iee_pkg::OP_ADD);
    // unmatched open bracket
    send_token(iee_pkg::KIND_OPEN, 0, iee_pkg::OP_ADD);
    send_token(iee_pkg::KIND_NUM, 5, iee_pkg::OP_ADD);
    send_token(iee_pkg::KIND_END, 0, iee_pkg::OP_ADD);
  endtask

  // signed corners: (0-max-1)/(0-1), (0-max-1)%(0-1), (0-1)^(0-3), (0-1) % (0-2)
  task automatic test_signed_corners();
    logic [2:0] finals [4];
    finals = '{iee_pkg::OP_DIV, iee_pkg::OP_REM, iee_pkg::OP_POW, iee_pkg::OP_REM};
    for (int i = 0; i < 4; i++) begin
      send_token(iee_pkg::KIND_OPEN, 0, iee_pkg::OP_ADD);
      send_token(iee_pkg::KIND_NUM, 0, iee_pkg::OP_ADD);
      send_token(iee_pkg::KIND_OPER, 0, iee_pkg::OP_SUB);
      send_token(iee_pkg::KIND_NUM, (i < 2) ? 31'h7FFFFFFF : 31'd1, iee_pkg::OP_ADD);
      if (i < 2) begin
        send_token(iee_pkg::KIND_OPER, 0, iee_pkg::OP_SUB);
        send_token(iee_pkg::KIND_NUM, 1, iee_pkg::OP_ADD);
      end
      send_token(iee_pkg::KIND_CLOSE, 0, iee_pkg::OP_ADD);
      send_token(iee_pkg::KIND_OPER, 0, finals[i]);
      send_token(iee_pkg::KIND_OPEN, 0, iee_pkg::OP_ADD);
      send_token(iee_pkg::KIND_NUM, 0, iee_pkg::OP_ADD);
      send_token(iee_pkg::KIND_OPER, 0, iee_pkg::OP_SUB);
      send_token(iee_pkg::KIND_NUM, (i == 2) ? 31'd3 : (i == 3 ? 31'd2 : 31'd1),
                 iee_pkg::OP_ADD);
      send_token(iee_pkg::KIND_CLOSE, 0, iee_pkg::OP_ADD);
      send_token(iee_pkg::KIND_END, 0, iee_pkg::OP_ADD);
    end
  endtask

  // overflow of both stacks
  task automatic test_overflow();
    repeat (VDEPTH + 1) send_token(iee_pkg::KIND_NUM, 31'($urandom()), iee_pkg::OP_ADD, 1'b0);
    send_token(iee_pkg::KIND_END, 0, iee_pkg::OP_ADD);
    repeat (ODEPTH + 1) send_token(iee_pkg::KIND_OPEN, 0, iee_pkg::OP_ADD, 1'b0);
    send_token(iee_pkg::KIND_END, 0, iee_pkg::OP_ADD);
  endtask

  // build a well-formed expression of random shape
  task automatic send_expr(int depth);
    int terms;
    terms = $urandom_range(1, 4);
    for (int t = 0; t < terms; t++) begin
      if (t > 0) send_token(iee_pkg::KIND_OPER, 0, 3'($urandom_range(0, 5)));
      if (depth < 3 && $urandom_range(0, 3) == 0) begin
        send_token(iee_pkg::KIND_OPEN, 0, iee_pkg::OP_ADD);
        send_expr(depth + 1);
        send_token(iee_pkg::KIND_CLOSE, 0, iee_pkg::OP_ADD);
      end else send_token(iee_pkg::KIND_NUM, rand_num(), iee_pkg::OP_ADD);
    end
  endtask

  // mostly well-formed expressions, some noise tokens
  task automatic test_random(int goal);
    int start;
    start = n_tokens;
    while (n_tokens - start < goal) begin
      if ($urandom_range(0, 9) < 8) send_expr(0);
      else repeat ($urandom_range(1, 6))
        send_token(3'($urandom_range(0, 7)), 31'($urandom()), rand_op());
      send_token(iee_pkg::KIND_END, 0, iee_pkg::OP_ADD);
    end
  endtask

  // sink holds off while the source keeps offering
  task automatic test_backpressure();
    hold_cycles = 0;
    sink_long_hold = 1'b1;
    repeat (40) begin
      send_token(iee_pkg::KIND_NUM, 31'($urandom_range(0, 99)), iee_pkg::OP_ADD, 1'b0);
      send_token(iee_pkg::KIND_END, 0, iee_pkg::OP_ADD, 1'b0);
    end
    wait_drain();
  endtask

  initial begin
    tok.valid = 1'b0;
    tok.kind = iee_pkg::KIND_NUM;
    tok.number_value = '0;
    tok.operator_code = iee_pkg::OP_ADD;
    errors = 0;
    n_tokens = 0;
    n_results = 0;
    n_bad_status = 0;
    hold_cycles = 0;
    sink_long_hold = 1'b0;
    vcnt = 0;
    ocnt = 0;
    err = iee_pkg::ST_OK;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_signed_corners();
    wait_drain();
    test_overflow();
    test_backpressure();
    test_random(1620);
    wait_drain();
    repeat (200) @(posedge clk);
    $display("Sent %0d token words, checked %0d result words (%0d with error status).",
             n_tokens, n_results, n_bad_status);
    if (errors == 0 && answers.size() == 0)
      $display("infix_expression_evaluator_core: match");
    else
      $display("infix_expression_evaluator_core: mismatch");
    $finish;
  end

  initial begin
    #20ms;
    $display("infix_expression_evaluator_core: mismatch");
    $finish;
  end

endmodule
